// ===== sv/newton_square_root_solver_core_macros.svh =====
// Assertion macros used by the solver core RTL file.
`ifndef NEWTON_SQUARE_ROOT_SOLVER_CORE_MACROS_SVH
`define NEWTON_SQUARE_ROOT_SOLVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define NSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NSR_ASSERT_IMP(lbl, ante, cons)
`define NSR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/nsr_pkg.sv =====
// Package with widths, types and constants of the Newton square root solver.
package nsr_pkg;
    localparam int DATA_W = 64;
    localparam int FRAC_W = 24;
    localparam int WIDE_W = 2 * DATA_W;
    localparam int HALF_W = DATA_W / 2;
    localparam int CNT_W = 8;
    localparam int TGT_W = 62;
    localparam int TOL_W = 25;
    localparam int MAG_W = 63;
    localparam int CFG_W = 63;
    localparam int OUT_W = 2;

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_TOL = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;
    localparam logic [1:0] REG_MAG = 2'd3;

    localparam logic [OUT_W-1:0] OUT_CONVERGED = 2'd0;
    localparam logic [OUT_W-1:0] OUT_LIMIT = 2'd1;
    localparam logic [OUT_W-1:0] OUT_OVERFLOW = 2'd2;

    localparam logic [DATA_W-1:0] NEG_END = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic busy;
        logic done;
    } nsr_stat_t;
endpackage

// ===== sv/nsr_if.sv =====
// Handshake interfaces for the request and result channels.
interface nsr_in_if import nsr_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [DATA_W-1:0] initial_guess;
    modport source (output valid, output initial_guess, input ready);
    modport sink (input valid, input initial_guess, output ready);
endinterface

interface nsr_out_if import nsr_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [DATA_W-1:0] root_estimate;
    logic [CNT_W-1:0] iterations_used;
    logic [OUT_W-1:0] outcome;
    modport source (output valid, output root_estimate, output iterations_used,
                    output outcome, input ready);
    modport sink (input valid, input root_estimate, input iterations_used,
                  input outcome, output ready);
endinterface

// ===== sv/newton_square_root_solver_core.sv =====
// Newton-Raphson square root solver: sequencer with shared squarer and divider.
// The request channel in_ch carries one starting guess; ready is high only while the
// block is idle. Each Newton step passes the check, multiply, divide and update states:
// it squares x on a 32x32 multiplier and divides the residual by x on a bit-serial
// divider. The result is offered after the last step, and the next request can be
// taken once the block returns to idle after the result leaves; the step count is
// bounded by the iteration limit, with at least one step.
// A zero starting guess ends in the check state with an overflow status.
// The divider dominates each step: it produces one quotient bit per cycle.
// One result per request leaves on out_ch with the final x, the step count and a
// status. The result stays valid until the receiver takes it; a stalled receiver
// holds the block, and no new request is taken until the result is gone.
// Configuration is written through cfg_en, cfg_index and cfg_data; the user must write
// it only while idle, as the block does not enforce this. Reset clears the sequencer
// and loads the default register values; with no clearing pass, the block is ready at once.
`include "newton_square_root_solver_core_macros.svh"
module newton_square_root_solver_core import nsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    nsr_in_if.sink           in_ch,
    nsr_out_if.source        out_ch
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [TGT_W-1:0] target_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [MAG_W-1:0] mag_reg;

    logic [DATA_W-1:0] xmag_reg, xmag_next;
    logic xneg_reg, xneg_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic nneg_reg, nneg_next;

    logic mul_start, div_start;
    nsr_stat_t mul_stat, div_stat;
    logic [WIDE_W-1:0] sq, quot, cs, num;
    logic cs_ge;

    logic [WIDE_W-1:0] qs;
    logic big, dneg, rneg, rneg_f;
    logic [DATA_W-1:0] dmag, rmag, lim_end;
    logic [DATA_W:0] sum;
    logic [DATA_W-1:0] gmag;

    nsr_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(xmag_reg),
        .stat(mul_stat), .product(sq)
    );

    nsr_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num), .den(xmag_reg),
        .stat(div_stat), .quotient(quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TGT_W'(64'd67108864);
            tol_reg <= TOL_W'(17);
            limit_reg <= CNT_W'(100);
            mag_reg <= {1'b1, {(MAG_W-1){1'b0}}};
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_TARGET: target_reg <= cfg_data[TGT_W-1:0];
                REG_TOL:    tol_reg <= cfg_data[TOL_W-1:0];
                REG_LIMIT:  limit_reg <= cfg_data[CNT_W-1:0];
                REG_MAG:    mag_reg <= cfg_data[MAG_W-1:0];
                default:    target_reg <= target_reg;
            endcase
        end
    end

    always_comb
    begin
        cs = {{(WIDE_W-TGT_W-FRAC_W){1'b0}}, target_reg, {FRAC_W{1'b0}}};
        cs_ge = cs >= sq;
        num = cs_ge ? cs - sq : sq - cs;
        gmag = in_ch.initial_guess[DATA_W-1] ? DATA_W'(-in_ch.initial_guess)
                                              : in_ch.initial_guess;

        qs = quot >> 1;
        dneg = (nneg_reg != xneg_reg) && (qs != '0);
        big = (qs[WIDE_W-1:DATA_W] != '0) || (qs[DATA_W-1:0] > NEG_END);
        dmag = big ? NEG_END : qs[DATA_W-1:0];
        sum = {1'b0, xmag_reg} + {1'b0, dmag};
        if (dneg == xneg_reg)
        begin
            rmag = sum[DATA_W-1:0];
            rneg = xneg_reg;
            if (sum[DATA_W])
                big = 1'b1;
        end
        else if (xmag_reg >= dmag)
        begin
            rmag = xmag_reg - dmag;
            rneg = xneg_reg;
        end
        else
        begin
            rmag = dmag - xmag_reg;
            rneg = dneg;
        end
        if (big)
            rneg = dneg;
        lim_end = rneg ? NEG_END : NEG_END - 1'b1;
        rneg_f = (rmag == '0) ? 1'b0 : rneg;
    end

    always_comb
    begin
        state_next = state_reg;
        xmag_next = xmag_reg;
        xneg_next = xneg_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        nneg_next = nneg_reg;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    xneg_next = in_ch.initial_guess[DATA_W-1];
                    xmag_next = gmag;
                    count_next = '0;
                    ovf_next = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                count_next = count_reg + 1'b1;
                if (xmag_reg == '0)
                begin
                    ovf_next = 1'b1;
                    xneg_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    mul_start = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    nneg_next = !cs_ge;
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (big || rmag > lim_end)
                begin
                    xmag_next = lim_end;
                    xneg_next = rneg;
                    ovf_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    xmag_next = rmag;
                    xneg_next = rneg_f;
                    if (rmag > {1'b0, mag_reg})
                    begin
                        ovf_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (qs <= {{(WIDE_W-TOL_W){1'b0}}, tol_reg})
                        state_next = ST_DONE;
                    else if (count_reg >= limit_reg)
                        state_next = ST_DONE;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            xneg_reg <= 1'b0;
            nneg_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            xneg_reg <= xneg_next;
            nneg_reg <= nneg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xmag_reg <= xmag_next;
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_DONE);
    assign out_ch.root_estimate = xneg_reg ? DATA_W'(-xmag_reg) : xmag_reg;
    assign out_ch.iterations_used = count_reg;
    assign out_ch.outcome = ovf_reg ? OUT_OVERFLOW :
                            (count_reg == limit_reg) ? OUT_LIMIT : OUT_CONVERGED;

    `NSR_ASSERT_NXT(a_accept_starts, in_ch.valid && in_ch.ready, state_reg == ST_CHECK)
    `NSR_ASSERT_IMP(a_done_has_count, state_reg == ST_DONE, count_reg != '0)
    `NSR_ASSERT_IMP(a_outcome_code, out_ch.valid,
        out_ch.outcome == OUT_CONVERGED || out_ch.outcome == OUT_LIMIT ||
        out_ch.outcome == OUT_OVERFLOW)
    `NSR_ASSERT_IMP(a_units_idle, state_reg == ST_IDLE, !mul_stat.busy && !div_stat.busy)
endmodule

// ===== sv/nsr_mul.sv =====
// Iterative squarer built from one shared 32 by 32 multiplier over four partial products.
module nsr_mul import nsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    output nsr_stat_t         stat,
    output logic [WIDE_W-1:0] product
);
    logic [DATA_W-1:0] a_reg;
    logic [2:0] k_reg;
    logic busy_reg, done_reg, pv_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [1:0] sh_reg;
    logic [WIDE_W-1:0] acc_reg;
    logic [HALF_W-1:0] op_a, op_b;

    always_comb
    begin
        op_a = k_reg[1] ? a_reg[DATA_W-1:HALF_W] : a_reg[HALF_W-1:0];
        op_b = k_reg[0] ? a_reg[DATA_W-1:HALF_W] : a_reg[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pv_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                pv_reg <= 1'b0;
                k_reg <= '0;
            end
            else if (busy_reg)
            begin
                pv_reg <= (k_reg != 3'd4);
                if (k_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                k_reg <= k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (k_reg != 3'd4)
            begin
                prod_reg <= op_a * op_b;
                sh_reg <= {1'b0, k_reg[0]} + {1'b0, k_reg[1]};
            end
            if (pv_reg)
                acc_reg <= acc_reg + ({{DATA_W{1'b0}}, prod_reg} << {sh_reg, 5'b0});
        end
    end

    assign stat = '{busy: busy_reg, done: done_reg};
    assign product = acc_reg;
endmodule

// ===== sv/nsr_div.sv =====
// Restoring divider, one quotient bit per cycle, wide numerator by a data-width divisor.
module nsr_div import nsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] num,
    input  logic [DATA_W-1:0] den,
    output nsr_stat_t         stat,
    output logic [WIDE_W-1:0] quotient
);
    localparam int CW = $clog2(WIDE_W);

    logic [WIDE_W-1:0] num_reg, quot_reg;
    logic [DATA_W-1:0] den_reg, rem_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [DATA_W:0] trial;
    logic fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[WIDE_W-1]};
        fits = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(WIDE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[WIDE_W-2:0], 1'b0};
            rem_reg <= fits ? DATA_W'(trial - {1'b0, den_reg}) : trial[DATA_W-1:0];
            quot_reg <= {quot_reg[WIDE_W-2:0], fits};
        end
    end

    assign stat = '{busy: busy_reg, done: done_reg};
    assign quotient = quot_reg;
endmodule

// ===== verif/nsr_checker.sv =====
// Checker that predicts each solver result and compares it with the result channel.
module nsr_checker import nsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    nsr_in_if                in_ch,
    nsr_out_if               out_ch,
    output int               fail_count,
    output int               pending_roots,
    output int               roots_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [DATA_W-1:0] root;
        logic [CNT_W-1:0]  steps;
        logic [OUT_W-1:0]  status;
    } root_result_t;

    logic [TGT_W-1:0] target_sq;
    logic [TOL_W-1:0] tolerance;
    logic [CNT_W-1:0] step_limit;
    logic [MAG_W-1:0] mag_limit;
    root_result_t     expected_roots[$];

    function automatic root_result_t solve_root(logic [DATA_W-1:0] guess);
        root_result_t r;
        logic              xneg;
        logic [DATA_W-1:0] xmag;
        logic [DATA_W-1:0] dmag;
        logic [DATA_W-1:0] rmag;
        logic [DATA_W-1:0] end_mag;
        logic [DATA_W:0]   sum;
        logic [WIDE_W-1:0] scaled_c;
        logic [WIDE_W-1:0] sq;
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] q;
        logic              nneg;
        logic              dneg;
        logic              rneg;
        logic              big;
        logic              ovf;
        int                count;
        xneg = guess[DATA_W-1];
        xmag = xneg ? -guess : guess;
        count = 0;
        ovf = 1'b0;
        scaled_c = {{(WIDE_W-TGT_W){1'b0}}, target_sq} << FRAC_W;
        forever begin
            count++;
            if (xmag == '0) begin
                ovf = 1'b1;
                xneg = 1'b0;
                break;
            end
            sq = {{DATA_W{1'b0}}, xmag} * {{DATA_W{1'b0}}, xmag};
            if (scaled_c >= sq) begin
                num = scaled_c - sq;
                nneg = 1'b0;
            end
            else begin
                num = sq - scaled_c;
                nneg = 1'b1;
            end
            q = (num / {{DATA_W{1'b0}}, xmag}) >> 1;
            dneg = (nneg != xneg) && (q != '0);
            big = (q[WIDE_W-1:DATA_W] != '0) || (q[DATA_W-1:0] > NEG_END);
            dmag = big ? NEG_END : q[DATA_W-1:0];
            if (dneg == xneg) begin
                sum = {1'b0, xmag} + {1'b0, dmag};
                rmag = sum[DATA_W-1:0];
                rneg = xneg;
                if (sum[DATA_W]) big = 1'b1;
            end
            else if (xmag >= dmag) begin
                rmag = xmag - dmag;
                rneg = xneg;
            end
            else begin
                rmag = dmag - xmag;
                rneg = dneg;
            end
            if (big) rneg = dneg;
            end_mag = rneg ? NEG_END : NEG_END - 1;
            if (big || rmag > end_mag) begin
                xmag = end_mag;
                xneg = rneg;
                ovf = 1'b1;
                break;
            end
            if (rmag == '0) rneg = 1'b0;
            xmag = rmag;
            xneg = rneg;
            if (xmag > {1'b0, mag_limit}) begin
                ovf = 1'b1;
                break;
            end
            if (q <= {{(WIDE_W-TOL_W){1'b0}}, tolerance}) break;
            if (count >= step_limit) break;
        end
        if (ovf) r.status = OUT_OVERFLOW;
        else if (count == step_limit) r.status = OUT_LIMIT;
        else r.status = OUT_CONVERGED;
        r.root = xneg ? -xmag : xmag;
        r.steps = count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        root_result_t want;
        if (!rst_n) begin
            target_sq <= TGT_W'(64'd67108864);
            tolerance <= TOL_W'(17);
            step_limit <= CNT_W'(100);
            mag_limit <= MAG_W'(64'h4000_0000_0000_0000);
            expected_roots.delete();
            fail_count <= 0;
            pending_roots <= 0;
            roots_seen <= 0;
        end
        else begin
            if (cfg_en) begin
                case (cfg_index)
                    REG_TARGET: target_sq <= cfg_data[TGT_W-1:0];
                    REG_TOL:    tolerance <= cfg_data[TOL_W-1:0];
                    REG_LIMIT:  step_limit <= cfg_data[CNT_W-1:0];
                    REG_MAG:    mag_limit <= cfg_data[MAG_W-1:0];
                    default:    ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_roots.push_back(solve_root(in_ch.initial_guess));
            if (out_ch.valid && out_ch.ready) begin
                roots_seen <= roots_seen + 1;
                if (expected_roots.size() == 0) begin
                    report("unexpected result", out_ch.root_estimate, '0);
                end
                else begin
                    want = expected_roots.pop_front();
                    if (out_ch.root_estimate !== want.root)
                        report("root_estimate", out_ch.root_estimate, want.root);
                    if (out_ch.iterations_used !== want.steps)
                        report("iterations_used", 64'(out_ch.iterations_used), 64'(want.steps));
                    if (out_ch.outcome !== want.status)
                        report("outcome", 64'(out_ch.outcome), 64'(want.status));
                end
            end
            pending_roots <= expected_roots.size();
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// Top of the solver testbench: clock, reset, stimulus, configuration and verdict.
module tb_top import nsr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 12_000_000;
    localparam logic [DATA_W-1:0] ONE = 64'd1 << FRAC_W;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_en = 1'b0;
    logic [1:0]       cfg_index = REG_TARGET;
    logic [CFG_W-1:0] cfg_data = '0;
    int               fail_count;
    int               pending_roots;
    int               roots_seen;
    longint           cycles = 0;
    bit               hold_results = 1'b0;
    bit               steady = 1'b0;
    int               requests_sent = 0;

    nsr_in_if  in_ch();
    nsr_out_if out_ch();

    newton_square_root_solver_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_en(cfg_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    nsr_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_en(cfg_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .pending_roots(pending_roots), .roots_seen(roots_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_results) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_results = 1'b0;
            end
            gap = steady ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send_guess(logic [DATA_W-1:0] guess);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.initial_guess <= guess;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_roots != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic set_solver(logic [CFG_W-1:0] c, logic [CFG_W-1:0] tol,
                              logic [CFG_W-1:0] lim, logic [CFG_W-1:0] mag);
        write_reg(REG_TARGET, c);
        write_reg(REG_TOL, tol);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_MAG, mag);
    endtask

    function automatic logic [DATA_W-1:0] random_guess();
        logic [DATA_W-1:0] g;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) g = 64'($urandom_range(0, 32'h1000_0000));
        else if (pick < 6) g = {$urandom, $urandom};
        else if (pick < 8) g = 64'($urandom_range(0, 32'h0400_0000)) + ONE;
        else g = 64'($urandom_range(1, 4)) << $urandom_range(0, 62);
        if ($urandom_range(0, 2) == 0) g = -g;
        return g;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_guess(random_guess());
        wait_idle();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.initial_guess = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        steady = 1'b1;
        send_guess('0);
        send_guess(64'd1);
        send_guess(-64'd1);
        send_guess(2 * ONE);
        send_guess(-2 * ONE);
        send_guess(ONE);
        send_guess(64'h7FFF_FFFF_FFFF_FFFF);
        send_guess(64'h8000_0000_0000_0000);
        send_guess(64'h8000_0000_0000_0001);
        send_guess(64'h0000_0010_0000_0000);
        send_guess(64'h4000_0000_0000_0001);
        steady = 1'b0;
        wait_idle();

        set_solver('0, '0, 63'd1, 63'd1);
        send_guess(ONE);
        send_guess(-ONE);
        send_guess(64'd1);
        send_guess('0);
        wait_idle();

        set_solver('0, 63'd4, 63'd255, 63'h7FFF_FFFF_FFFF_FFFF);
        send_guess(64'h7FFF_FFFF_FFFF_FFFF);
        send_guess(64'h8000_0000_0000_0000);
        wait_idle();

        set_solver(63'h3FFF_FFFF_FFFF_FFFF, 63'h100_0000, 63'd255, 63'h4000_0000_0000_0000);
        send_guess(ONE);
        send_guess(64'h7FFF_FFFF_FFFF_FFFF);
        send_guess(-64'h0000_0100_0000_0000);
        send_guess(64'd1);
        wait_idle();

        set_solver(63'd67108864, 63'd17, 63'd0, 63'h4000_0000_0000_0000);
        send_guess(3 * ONE);
        wait_idle();

        set_solver(63'd9 << FRAC_W, 63'd17, 63'd40, 63'h0000_0100_0000_0000);
        hold_results = 1'b1;
        random_phase(20);

        set_solver(63'($urandom_range(1, 32'hFFFF_FFFF)) << 8, 63'($urandom_range(0, 4096)),
                   63'($urandom_range(1, 60)), {$urandom, $urandom} >> 1);
        random_phase(20);

        set_solver({$urandom, $urandom} >> 2, 63'($urandom_range(0, 32'h100_0000)),
                   63'($urandom_range(1, 255)), 63'h4000_0000_0000_0000);
        random_phase(20);

        steady = 1'b1;
        set_solver(63'd2 << FRAC_W, 63'd1, 63'd100, 63'h7FFF_FFFF_FFFF_FFFF);
        random_phase(20);

        $display("Ran %0d requests and checked %0d results across nine register settings,",
                 requests_sent, roots_seen);
        $display("including zero, saturated and overflowing guesses and a long result stall.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
